FILE: sv/positional_list_insert_delete_defines.svh
// Assertion helpers shared by the list block.
// Both forms sample on the rising edge of aclk and stay quiet while reset is held.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// A property that must hold at every sampled edge.
`define PLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// A condition at one edge that requires another condition at the next edge.
`define PLI_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pli_pkg.sv
`default_nettype none

package pli_pkg;

    localparam int CAPACITY = 64;

    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;
    localparam int STS_W  = 2;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int GRP_SIZE = 8;
    localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STS_W-1:0] {
        STS_DONE = 2'd0,
        STS_POS  = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GATHER
    } state_t;

    // Shift command broadcast to every cell of the list.
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [CMP_W-1:0]  pos0;
        logic [WORD_W-1:0] value;
    } ctl_t;

endpackage

`default_nettype wire

FILE: sv/pli_cell.sv
`default_nettype none

// One list slot. It keeps its word, takes the inserted word when an insert
// lands on it, the left neighbor's word when an insert lands below it, or the
// right neighbor's word when a delete lands on it or below it.
module pli_cell (
    input  wire logic                        aclk,
    input  wire pli_pkg::ctl_t               ctl,
    input  wire logic [pli_pkg::CMP_W-1:0]   idx,
    input  wire logic [pli_pkg::WORD_W-1:0]  left_word,
    input  wire logic [pli_pkg::WORD_W-1:0]  right_word,
    output logic      [pli_pkg::WORD_W-1:0]  word,
    output logic      [pli_pkg::WORD_W-1:0]  tap
);

    logic [pli_pkg::WORD_W-1:0] entry_reg;
    logic [pli_pkg::WORD_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins_en) begin
            if (idx == ctl.pos0) begin
                entry_next = ctl.value;
            end else if (idx > ctl.pos0) begin
                entry_next = left_word;
            end
        end else if (ctl.del_en) begin
            if (idx >= ctl.pos0) begin
                entry_next = right_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign word = entry_reg;
    // The old word of the slot being deleted, zero everywhere else.
    assign tap  = (ctl.del_en && (idx == ctl.pos0)) ? entry_reg : '0;

endmodule

`default_nettype wire

FILE: sv/pli_gather.sv
`default_nettype none

// Two-level OR tree that collects the one nonzero tap of a delete.
// The first level is registered per group of cells.
module pli_gather (
    input  wire logic                        aclk,
    input  wire logic                        cap_en,
    input  wire logic [pli_pkg::WORD_W-1:0]  taps [pli_pkg::CAPACITY],
    output logic      [pli_pkg::WORD_W-1:0]  sel_word
);

    logic [pli_pkg::WORD_W-1:0] grp_reg  [pli_pkg::NGRP];
    logic [pli_pkg::WORD_W-1:0] grp_next [pli_pkg::NGRP];

    always_comb begin
        for (int g = 0; g < pli_pkg::NGRP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < pli_pkg::GRP_SIZE; k++) begin
                if (g * pli_pkg::GRP_SIZE + k < pli_pkg::CAPACITY) begin
                    grp_next[g] = grp_next[g] | taps[g * pli_pkg::GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_en) begin
            grp_reg <= grp_next;
        end
    end

    always_comb begin
        sel_word = '0;
        for (int g = 0; g < pli_pkg::NGRP; g++) begin
            sel_word = sel_word | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

FILE: sv/positional_list_insert_delete.sv
// Ordered list of signed 32-bit words with insert and delete at a 1-based position.
// Input channel s_*: one request per handshake (s_tvalid and s_tready high at a
// rising edge of aclk). s_tuser carries the opcode, s_tdata the position and value.
// Output channel m_*: one result per request, in order: status in m_tuser, the
// removed word and the new list length in m_tdata.
// Each request passes through the sequencer states execute, where the row of
// cells shifts and the registered OR tree captures the deleted word, and gather,
// where the result is loaded into the output register. A new request is taken
// only once the sequencer is back in idle.
// The input is taken again while an earlier result still waits on m_tready,
// since the result sits in its own output register. If the receiver stalls,
// the next result holds in the sequencer until the output register frees.
// Reset (aresetn low at a rising edge) empties the list and drops any
// pending result; the cell contents are not cleared, because only entries
// below the length are ever read, and all of them have been written.
// No clearing pass is needed, so a request is accepted right after reset.
`default_nettype none

`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, from bit 0: position[6:0], value[38:7], zero pad[39]
    input  wire logic [39:0] s_tdata,
    // s_tuser, from bit 0: opcode[0]
    input  wire logic        s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, from bit 0: removed_value[31:0], list_length[38:32], zero pad[39]
    output logic      [39:0] m_tdata,
    // m_tuser, from bit 0: status[1:0]
    output logic      [1:0]  m_tuser
);

    localparam int CAP   = pli_pkg::CAPACITY;
    localparam int CMP_W = pli_pkg::CMP_W;
    localparam int CNT_W = pli_pkg::CNT_W;

    // Sequencer and the request it is working on.
    pli_pkg::state_t state_reg;
    pli_pkg::state_t state_next;

    pli_pkg::op_t                 op_reg;
    logic [pli_pkg::POS_W-1:0]    pos_reg;
    logic [pli_pkg::WORD_W-1:0]   val_reg;
    logic [CNT_W-1:0]             count_reg;
    pli_pkg::status_t             status_reg;
    pli_pkg::status_t             status_c;

    logic                         m_tvalid_reg;
    logic [39:0]                  m_tdata_reg;
    logic [1:0]                   m_tuser_reg;

    logic                         accept;
    logic                         exec;
    logic                         out_load;
    logic                         out_fail;

    logic [CMP_W-1:0]             posx;
    logic [CMP_W-1:0]             cntx;
    logic                         ins_ok;
    logic                         del_ok;

    pli_pkg::ctl_t                ctl;

    logic [pli_pkg::WORD_W-1:0]   word_arr [CAP];
    logic [pli_pkg::WORD_W-1:0]   tap_arr  [CAP];
    logic [pli_pkg::WORD_W-1:0]   removed;

    // Range and capacity checks. A bad position wins over a full list.
    assign posx = CMP_W'(pos_reg);
    assign cntx = CMP_W'(count_reg);

    always_comb begin
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        status_c = pli_pkg::STS_DONE;
        if (op_reg == pli_pkg::OP_INSERT) begin
            if ((posx == '0) || (posx > cntx + CMP_W'(1))) begin
                status_c = pli_pkg::STS_POS;
            end else if (cntx == CMP_W'(CAP)) begin
                status_c = pli_pkg::STS_FULL;
            end else begin
                ins_ok = 1'b1;
            end
        end else begin
            if ((posx == '0) || (posx > cntx)) begin
                status_c = pli_pkg::STS_POS;
            end else begin
                del_ok = 1'b1;
            end
        end
    end

    // Next state and handshake control.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        exec       = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            pli_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = pli_pkg::ST_EXEC;
                end
            end
            pli_pkg::ST_EXEC: begin
                exec       = 1'b1;
                state_next = pli_pkg::ST_GATHER;
            end
            pli_pkg::ST_GATHER: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = pli_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pli_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request latch. Payload only, so no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= pli_pkg::op_t'(s_tuser);
            pos_reg <= s_tdata[6:0];
            val_reg <= s_tdata[38:7];
        end
        if (exec) begin
            status_reg <= status_c;
        end
    end

    // List length.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (exec && ins_ok) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (exec && del_ok) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Command seen by every cell during the execute cycle.
    always_comb begin
        ctl.ins_en = exec && ins_ok;
        ctl.del_en = exec && del_ok;
        ctl.pos0   = posx - CMP_W'(1);
        ctl.value  = val_reg;
    end

    // The row of cells: cell i holds list entry i (0-based).
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic [pli_pkg::WORD_W-1:0] left_w;
        logic [pli_pkg::WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = val_reg;
        end else begin : g_inner_l
            assign left_w = word_arr[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner_r
            assign right_w = word_arr[i+1];
        end

        pli_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .idx        (CMP_W'(i)),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (word_arr[i]),
            .tap        (tap_arr[i])
        );
    end

    // The deleted word is captured in the execute cycle from the old contents.
    pli_gather u_gather (
        .aclk     (aclk),
        .cap_en   (exec),
        .taps     (tap_arr),
        .sel_word (removed)
    );

    // Output register. It frees when the receiver takes the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, pli_pkg::LEN_W'(count_reg), removed};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A failed request is waiting on the output.
    assign out_fail = m_tvalid_reg && (m_tuser_reg != pli_pkg::STS_DONE);

    // The length never grows past the number of cells.
    `PLI_ASSERT(a_count_cap, count_reg <= CNT_W'(CAP), "list length above capacity")

    // A taken request always goes straight to the execute cycle.
    `PLI_IMPLY(a_accept_exec, accept, state_reg == pli_pkg::ST_EXEC, "request not executed")

    // A successful insert lengthens the list by exactly one.
    `PLI_IMPLY(a_ins_count, ctl.ins_en, count_reg == $past(count_reg) + CNT_W'(1), "insert length")

    // A failed request never reports a removed word.
    `PLI_ASSERT(a_fail_zero, !out_fail || (m_tdata[31:0] == '0), "removed word on failure")

endmodule

`default_nettype wire

FILE: tb/positional_list_checker.sv
`timescale 1ns / 1ps

module positional_list_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // s_tdata, from bit 0: position[6:0], value[38:7], zero pad[39]
    input  wire logic [39:0] s_tdata,
    // s_tuser, from bit 0: opcode[0]
    input  wire logic        s_tuser,

    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, from bit 0: removed_value[31:0], list_length[38:32], zero pad[39]
    input  wire logic [39:0] m_tdata,
    // m_tuser, from bit 0: status[1:0]
    input  wire logic [1:0]  m_tuser,

    output int               fail_count,
    output int               pending_count
);
    import pli_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] removed;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    logic [WORD_W-1:0] list_words [CAPACITY];
    int                list_len = 0;
    list_result_t      awaited_results [$];
    list_result_t      oldest;
    int                errors = 0;

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic list_result_t apply_list_op(op_t op, int pos, logic [WORD_W-1:0] val);
        list_result_t res;
        res.status  = STS_DONE;
        res.removed = '0;
        if (op == OP_INSERT) begin
            if (pos < 1 || pos > list_len + 1) begin
                res.status = STS_POS;
            end else if (list_len >= CAPACITY) begin
                res.status = STS_FULL;
            end else begin
                for (int j = list_len; j >= pos; j--) begin
                    list_words[j] = list_words[j-1];
                end
                list_words[pos-1] = val;
                list_len++;
            end
        end else begin
            if (pos < 1 || pos > list_len) begin
                res.status = STS_POS;
            end else begin
                res.removed = list_words[pos-1];
                for (int j = pos; j < list_len; j++) begin
                    list_words[j-1] = list_words[j];
                end
                list_len--;
            end
        end
        res.length = list_len[LEN_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_results.delete();
            list_len = 0;
        end else begin
            // A result can never belong to a request taken at the same edge,
            // so the output side is handled first.
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d, removed_value %0d, list_length %0d",
                           m_tuser, $signed(m_tdata[31:0]), m_tdata[38:32]);
                    errors++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_tuser !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[31:0] !== oldest.removed) begin
                        $error("removed_value: expected %0d, got %0d",
                               $signed(oldest.removed), $signed(m_tdata[31:0]));
                        errors++;
                    end
                    if (m_tdata[38:32] !== oldest.length) begin
                        $error("list_length: expected %0d, got %0d",
                               oldest.length, m_tdata[38:32]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_list_op(op_t'(s_tuser), int'(s_tdata[6:0]),
                                                        s_tdata[38:7]));
            end
        end
        fail_count    <= errors;
        pending_count <= awaited_results.size();
    end

endmodule

FILE: tb/positional_list_insert_delete_tb.sv
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;
    import pli_pkg::*;

    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 7;     // chance in a hundred that a side idles
    localparam int NOISE_PCT      = 12;    // requests with a position drawn from the full range
    localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 20;    // quiet time after the last result
    localparam int CYCLE_LIMIT    = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata, from bit 0: position[6:0], value[38:7], zero pad[39]
    logic [39:0] s_tdata;
    // s_tuser, from bit 0: opcode[0]
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata, from bit 0: removed_value[31:0], list_length[38:32], zero pad[39]
    logic [39:0] m_tdata;
    // m_tuser, from bit 0: status[1:0]
    logic [1:0]  m_tuser;

    int fail_count;
    int pending_count;

    // Length of the list as the stimulus sees it, used only to aim positions
    // at the valid range most of the time.
    int stim_len;
    // When set, neither side inserts idle cycles.
    bit no_idle;
    // Raised by the stimulus to make the receiver hold off for a long stretch.
    bit rx_hold_req;
    int cycle_count = 0;

    positional_list_insert_delete u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    positional_list_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Any run that is still going at the limit has hung somewhere.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver. It takes results freely apart from random idle cycles, and on
    // request it refuses everything for a long stretch so that the output
    // register and the sequencer both fill and the block stops taking requests.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Extreme words show up now and then; everything else is a random word,
    // which over the run sets and clears every bit.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offers one request and returns at the edge where it is taken. Every call
    // starts at an edge with no assignment yet made to s_tvalid in that step,
    // so s_tvalid either stays high into the next request or drops for a gap.
    task automatic issue(input op_t op, input int pos, input logic [31:0] val);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, val, 7'(pos)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Track the length the block will hold after this request.
        if (op == OP_INSERT) begin
            if (pos >= 1 && pos <= stim_len + 1 && stim_len < CAPACITY) stim_len++;
        end else if (pos >= 1 && pos <= stim_len) begin
            stim_len--;
        end
    endtask

    // One random request. Most land on a valid position; the rest take any
    // position the field can hold, which mostly gives position errors.
    task automatic issue_random(input int insert_pct);
        op_t op;
        int  pos;
        if ($urandom_range(99) < insert_pct) op = OP_INSERT;
        else op = OP_DELETE;
        if ($urandom_range(99) < NOISE_PCT) begin
            pos = $urandom_range(127);
        end else if (op == OP_INSERT) begin
            pos = $urandom_range(stim_len + 1, 1);
        end else if (stim_len == 0) begin
            pos = 1;
        end else begin
            pos = $urandom_range(stim_len, 1);
        end
        issue(op, pos, pick_value());
    endtask

    // Sender pause: stop offering and wait until every result has come back.
    // The first edge lets the checker's count catch up with the last request.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_INSERT;
        no_idle     = 1'b0;
        rx_hold_req = 1'b0;
        stim_len    = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: bad positions on an empty list, appends and
        // inserts at the front and in the middle with extreme words, bad
        // positions at both ends of the field, then deletes of the last and
        // the first entry until the list is empty again.
        issue(OP_INSERT, 0, 32'h1234_5678);
        issue(OP_DELETE, 1, 32'hFFFF_FFFF);
        issue(OP_INSERT, 2, 32'h0000_0001);
        issue(OP_INSERT, 1, 32'h8000_0000);
        issue(OP_INSERT, 2, 32'h7FFF_FFFF);
        issue(OP_INSERT, 1, 32'h0000_0000);
        issue(OP_INSERT, 2, 32'hFFFF_FFFF);
        issue(OP_INSERT, 127, 32'hA5A5_A5A5);
        issue(OP_INSERT, 6, 32'h5A5A_5A5A);
        issue(OP_DELETE, 127, 32'h0000_0000);
        issue(OP_DELETE, 0, 32'h0000_0000);
        issue(OP_DELETE, 5, 32'h0000_0000);
        issue(OP_DELETE, 4, 32'h7FFF_FFFF);
        issue(OP_DELETE, 1, 32'h8000_0000);
        issue(OP_DELETE, 2, 32'h0000_0000);
        issue(OP_DELETE, 1, 32'h0000_0000);
        issue(OP_DELETE, 1, 32'h0000_0000);

        // Mixed traffic, slightly insert-heavy so the list grows.
        for (int i = 0; i < 80; i++) issue_random(60);

        // Receiver hold-off while the sender keeps offering requests.
        rx_hold_req = 1'b1;
        for (int i = 0; i < 20; i++) issue_random(60);

        // Fill the list to capacity, then knock on the full list: valid
        // positions give a full status, a position past the end still gives
        // a position error because that check comes first.
        while (stim_len < CAPACITY) issue_random(90);
        for (int i = 0; i < 6; i++) issue(OP_INSERT, $urandom_range(CAPACITY + 1, 1), pick_value());
        issue(OP_INSERT, CAPACITY + 2, pick_value());
        issue(OP_INSERT, 127, pick_value());
        issue(OP_DELETE, CAPACITY + 1, pick_value());
        issue(OP_DELETE, CAPACITY, pick_value());

        // Sender pause until the block has handed back everything.
        wait_for_results();

        // Back-to-back stretch with no idle cycles on either side.
        no_idle = 1'b1;
        for (int i = 0; i < 60; i++) issue_random(50);
        no_idle = 1'b0;

        // Drain the list down to empty, then delete from the empty list.
        while (stim_len > 0) issue_random(15);
        issue(OP_DELETE, 1, pick_value());
        issue(OP_DELETE, 0, pick_value());

        for (int i = 0; i < 80; i++) issue_random(55);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
